>>> rtl/core/rotation_matrix_to_quaternion_assert.svh
// Assertion macros for the rotation matrix to quaternion block.
// Used by the top level only; no other dependencies.
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// ante implies cons on the same edge
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// expr must never hold
`define RMQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("rmq assertion failed");

`endif

>>> rtl/core/rmq_pkg.sv
// Shared widths, types and helpers for the rotation matrix to quaternion pipeline.
// No dependencies.
`default_nettype none
package rmq_pkg;
    localparam int DW      = 16;              // element width
    localparam int FB      = 14;              // fraction bits
    localparam int SW      = DW + 3;          // width of sums of three elements
    localparam int NUM_W   = DW + 1;          // numerator magnitude
    localparam int RAD_W   = ((DW + FB + 2) / 2) * 2;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DVS_W   = ROOT_W + 1;      // divisor 2r
    localparam int DVD_W   = NUM_W + FB;      // mag << FB
    localparam int RES_W   = DVD_W + 1;       // signed quotient
    localparam int LATENCY = ROOT_W + DVD_W + 2;

    typedef enum logic [1:0] {LEAD_W, LEAD_X, LEAD_Y, LEAD_Z} t_lead;

    typedef struct packed {
        t_lead                  lead;
        logic                   degen;
        logic [2:0]             neg;
        logic [2:0][NUM_W-1:0]  mag;
    } t_side;

    typedef struct packed {
        t_lead              lead;
        logic               degen;
        logic [2:0]         neg;
        logic [ROOT_W-1:0]  root;
    } t_tail;

    function automatic logic [DW-1:0] sat(input logic signed [RES_W-1:0] v);
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        hi = RES_W'((64'sd1 <<< (DW - 1)) - 64'sd1);
        lo = -hi - RES_W'(1);
        if (v > hi)      sat = hi[DW-1:0];
        else if (v < lo) sat = lo[DW-1:0];
        else             sat = v[DW-1:0];
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/rmq_front.sv
// Input stage: branch selection, root argument and numerator magnitudes.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m11, i_m12, i_m13,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m21, i_m22, i_m23,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m31, i_m32, i_m33,
    output logic                               o_vld,
    output logic [rmq_pkg::RAD_W-1:0]          o_rad,
    output rmq_pkg::t_side                     o_side
);
    logic signed [rmq_pkg::SW-1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
    logic signed [rmq_pkg::SW-1:0] trace, a, one;
    logic signed [rmq_pkg::SW-1:0] num [3];
    rmq_pkg::t_lead                lead;
    logic                          r_vld;
    logic [rmq_pkg::RAD_W-1:0]     r_rad, n_rad;
    rmq_pkg::t_side                r_side, n_side;

    always_comb begin
        e11 = rmq_pkg::SW'(i_m11); e12 = rmq_pkg::SW'(i_m12); e13 = rmq_pkg::SW'(i_m13);
        e21 = rmq_pkg::SW'(i_m21); e22 = rmq_pkg::SW'(i_m22); e23 = rmq_pkg::SW'(i_m23);
        e31 = rmq_pkg::SW'(i_m31); e32 = rmq_pkg::SW'(i_m32); e33 = rmq_pkg::SW'(i_m33);
        one   = rmq_pkg::SW'(1) <<< rmq_pkg::FB;
        trace = e11 + e22 + e33;
        if (trace > 0)                lead = rmq_pkg::LEAD_W;
        else if (e11 > e22 && e11 > e33) lead = rmq_pkg::LEAD_X;
        else if (e22 > e33)           lead = rmq_pkg::LEAD_Y;
        else                          lead = rmq_pkg::LEAD_Z;
        // lanes hold the three non-lead components in w, x, y, z order
        unique case (lead)
            rmq_pkg::LEAD_W: begin
                a = trace + one;
                num[0] = e23 - e32; num[1] = e31 - e13; num[2] = e12 - e21;
            end
            rmq_pkg::LEAD_X: begin
                a = one + e11 - e22 - e33;
                num[0] = e23 - e32; num[1] = e21 + e12; num[2] = e31 + e13;
            end
            rmq_pkg::LEAD_Y: begin
                a = one + e22 - e11 - e33;
                num[0] = e31 - e13; num[1] = e21 + e12; num[2] = e32 + e23;
            end
            default: begin
                a = one + e33 - e11 - e22;
                num[0] = e12 - e21; num[1] = e31 + e13; num[2] = e32 + e23;
            end
        endcase
        n_side.lead  = lead;
        n_side.degen = (a <= 0);
        for (int k = 0; k < 3; k++) begin
            n_side.neg[k] = num[k][rmq_pkg::SW-1];
            n_side.mag[k] = num[k][rmq_pkg::SW-1] ? rmq_pkg::NUM_W'(-num[k])
                                                  : rmq_pkg::NUM_W'(num[k]);
        end
        if (a <= 0) n_rad = '0;
        else        n_rad = rmq_pkg::RAD_W'({a[rmq_pkg::DW:0], {rmq_pkg::FB{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else          r_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_side <= n_side;
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_side = r_side;
endmodule
`default_nettype wire

>>> rtl/core/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vld,
    input  wire logic [rmq_pkg::RAD_W-1:0]    i_rad,
    input  rmq_pkg::t_side                    i_side,
    output logic                              o_vld,
    output logic [rmq_pkg::ROOT_W-1:0]        o_root,
    output rmq_pkg::t_side                    o_side
);
    localparam int N  = rmq_pkg::ROOT_W;
    localparam int RW = rmq_pkg::ROOT_W + 3;

    logic                       s_vld  [N+1];
    logic [rmq_pkg::RAD_W-1:0]  s_rad  [N+1];
    logic [RW-1:0]              s_rem  [N+1];
    logic [N-1:0]               s_root [N+1];
    rmq_pkg::t_side             s_side [N+1];

    assign s_vld[0]  = i_vld;
    assign s_rad[0]  = i_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_side[0] = i_side;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                       r_vld;
        logic [rmq_pkg::RAD_W-1:0]  r_rad;
        logic [RW-1:0]              r_rem, n_rem, cur, trial;
        logic [N-1:0]               r_root, n_root;
        rmq_pkg::t_side             r_side;

        always_comb begin
            cur   = {s_rem[k][RW-3:0], s_rad[k][rmq_pkg::RAD_W-1 -: 2]};
            trial = {1'b0, s_root[k], 2'b01};
            if (cur >= trial) begin
                n_rem  = cur - trial;
                n_root = {s_root[k][N-2:0], 1'b1};
            end else begin
                n_rem  = cur;
                n_root = {s_root[k][N-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld <= 1'b0;
            else          r_vld <= s_vld[k];
        end

        always_ff @(posedge i_clk) begin
            r_rad  <= s_rad[k] << 2;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= s_side[k];
        end

        assign s_vld[k+1]  = r_vld;
        assign s_rad[k+1]  = r_rad;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_side[k+1] = r_side;
    end

    assign o_vld  = s_vld[N];
    assign o_root = s_root[N];
    assign o_side = s_side[N];
endmodule
`default_nettype wire

>>> rtl/core/rmq_div.sv
// Three-lane pipelined restoring divider: mag * 2^FB / (2 * root), one bit per stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic [rmq_pkg::ROOT_W-1:0]    i_root,
    input  rmq_pkg::t_side                     i_side,
    output logic                               o_vld,
    output logic [2:0][rmq_pkg::DVD_W-1:0]     o_quo,
    output rmq_pkg::t_tail                     o_tail
);
    localparam int N  = rmq_pkg::DVD_W;
    localparam int DV = rmq_pkg::DVS_W;

    logic                    s_vld  [N+1];
    logic [2:0][N-1:0]       s_dvd  [N+1];
    logic [2:0][DV-1:0]      s_rem  [N+1];
    logic [2:0][N-1:0]       s_quo  [N+1];
    rmq_pkg::t_tail          s_tail [N+1];

    assign s_vld[0]  = i_vld;
    assign s_tail[0] = {i_side.lead, i_side.degen, i_side.neg, i_root};
    assign s_dvd[0]  = {{i_side.mag[2], {rmq_pkg::FB{1'b0}}},
                        {i_side.mag[1], {rmq_pkg::FB{1'b0}}},
                        {i_side.mag[0], {rmq_pkg::FB{1'b0}}}};
    assign s_rem[0]  = '0;
    assign s_quo[0]  = '0;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                r_vld;
        logic [2:0][N-1:0]   r_dvd, r_quo, n_quo;
        logic [2:0][DV-1:0]  r_rem, n_rem;
        rmq_pkg::t_tail      r_tail;
        logic [DV:0]         cur [3];
        logic [DV:0]         dvs;

        always_comb begin
            dvs = {1'b0, s_tail[k].root, 1'b0};
            for (int j = 0; j < 3; j++) begin
                cur[j] = {s_rem[k][j], s_dvd[k][j][N-1]};
                if (cur[j] >= dvs) begin
                    n_rem[j] = DV'(cur[j] - dvs);
                    n_quo[j] = {s_quo[k][j][N-2:0], 1'b1};
                end else begin
                    n_rem[j] = DV'(cur[j]);
                    n_quo[j] = {s_quo[k][j][N-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld <= 1'b0;
            else          r_vld <= s_vld[k];
        end

        always_ff @(posedge i_clk) begin
            for (int j = 0; j < 3; j++) r_dvd[j] <= s_dvd[k][j] << 1;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_tail <= s_tail[k];
        end

        assign s_vld[k+1]  = r_vld;
        assign s_dvd[k+1]  = r_dvd;
        assign s_rem[k+1]  = r_rem;
        assign s_quo[k+1]  = r_quo;
        assign s_tail[k+1] = r_tail;
    end

    assign o_vld  = s_vld[N];
    assign o_quo  = s_quo[N];
    assign o_tail = s_tail[N];
endmodule
`default_nettype wire

>>> rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix (Q2.14) to unit quaternion, fully pipelined.
// Pipeline from start to o_strobe: 1 input stage, 16 square-root stages,
// 31 divider stages and 1 output stage; rmq_pkg::LATENCY sums these stages.
// Throughput: one item per cycle; busy is never raised, the receiver cannot stall.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div and the assertion header.
`default_nettype none
`include "rotation_matrix_to_quaternion_assert.svh"
module rotation_matrix_to_quaternion (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m11, i_m12, i_m13,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m21, i_m22, i_m23,
    input  wire logic signed [rmq_pkg::DW-1:0] i_m31, i_m32, i_m33,
    output logic                               o_strobe,
    output logic signed [rmq_pkg::DW-1:0]      o_qw,
    output logic signed [rmq_pkg::DW-1:0]      o_qx,
    output logic signed [rmq_pkg::DW-1:0]      o_qy,
    output logic signed [rmq_pkg::DW-1:0]      o_qz,
    output logic                               o_degenerate
);
    logic                                 f_vld, q_vld, d_vld;
    logic [rmq_pkg::RAD_W-1:0]            f_rad;
    rmq_pkg::t_side                       f_side, q_side;
    logic [rmq_pkg::ROOT_W-1:0]           q_root;
    logic [2:0][rmq_pkg::DVD_W-1:0]       d_quo;
    rmq_pkg::t_tail                       d_tail;
    logic [rmq_pkg::DW-1:0]               lane [3];
    logic [rmq_pkg::DW-1:0]               half;
    logic signed [rmq_pkg::RES_W-1:0]     sq;
    logic                                 r_strobe, r_degen, n_degen;
    logic [rmq_pkg::DW-1:0]               r_qw, r_qx, r_qy, r_qz, n_qw, n_qx, n_qy, n_qz;

    assign busy = 1'b0;

    rmq_front u_front (
        .i_clk, .i_rst_n, .i_vld(start),
        .i_m11, .i_m12, .i_m13, .i_m21, .i_m22, .i_m23, .i_m31, .i_m32, .i_m33,
        .o_vld(f_vld), .o_rad(f_rad), .o_side(f_side)
    );

    rmq_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_vld(f_vld), .i_rad(f_rad), .i_side(f_side),
        .o_vld(q_vld), .o_root(q_root), .o_side(q_side)
    );

    rmq_div u_div (
        .i_clk, .i_rst_n, .i_vld(q_vld), .i_root(q_root), .i_side(q_side),
        .o_vld(d_vld), .o_quo(d_quo), .o_tail(d_tail)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sq = rmq_pkg::RES_W'(d_quo[j]);
            if (d_tail.neg[j]) sq = -sq;
            lane[j] = rmq_pkg::sat(sq);
        end
        half = rmq_pkg::sat(rmq_pkg::RES_W'(d_tail.root >> 1));
        unique case (d_tail.lead)
            rmq_pkg::LEAD_W: begin
                n_qw = half;    n_qx = lane[0]; n_qy = lane[1]; n_qz = lane[2];
            end
            rmq_pkg::LEAD_X: begin
                n_qw = lane[0]; n_qx = half;    n_qy = lane[1]; n_qz = lane[2];
            end
            rmq_pkg::LEAD_Y: begin
                n_qw = lane[0]; n_qx = lane[1]; n_qy = half;    n_qz = lane[2];
            end
            default: begin
                n_qw = lane[0]; n_qx = lane[1]; n_qy = lane[2]; n_qz = half;
            end
        endcase
        n_degen = d_tail.degen;
        if (d_tail.degen) begin
            n_qw = '0; n_qx = '0; n_qy = '0; n_qz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= d_vld;
    end

    always_ff @(posedge i_clk) begin
        r_qw    <= n_qw;
        r_qx    <= n_qx;
        r_qy    <= n_qy;
        r_qz    <= n_qz;
        r_degen <= n_degen;
    end

    assign o_strobe     = r_strobe;
    assign o_qw         = r_qw;
    assign o_qx         = r_qx;
    assign o_qy         = r_qy;
    assign o_qz         = r_qz;
    assign o_degenerate = r_degen;

    // a degenerate item carries all-zero components
    `RMQ_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, o_strobe && o_degenerate,
        o_qw == '0 && o_qx == '0 && o_qy == '0 && o_qz == '0)
    // the w-led branch always has a positive root argument
    `RMQ_ASSERT_NEVER(a_w_not_degen, i_clk, i_rst_n,
        d_vld && d_tail.degen && d_tail.lead == rmq_pkg::LEAD_W)
    // a live non-degenerate item never reaches the divider with a zero root
    `RMQ_ASSERT_NEVER(a_root_nonzero, i_clk, i_rst_n,
        q_vld && !q_side.degen && q_root == '0)
endmodule
`default_nettype wire
